// ----- src/wnaf_pkg.sv -----
// ============================================================================
// Weekly next-alarm finder package
// Shared constants, slot record type, distance result type and small helpers.
// ============================================================================
`default_nettype none

package wnaf_pkg;

  localparam int SlotCount   = 8;
  localparam int SlotIdxW    = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int NumDays     = 7;
  localparam int MinPerHour  = 60;
  localparam int HoursPerDay = 24;
  localparam int MinPerDay   = HoursPerDay * MinPerHour;
  localparam int NoHitDist   = (NumDays * MinPerDay) + 1;
  localparam int RampMax     = 180;
  localparam int RampReset   = 30;
  localparam int DistW       = 14;
  localparam int NowMinW     = 11;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_FIND    = 2'd1,
    CMD_TRIGGER = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic       hidden;
    logic       enable;
    logic       repeat_en;
    logic [6:0] days;
  } slot_t;

  localparam slot_t SlotDefault = '{hour: 5'd7, minute: 6'd0, hidden: 1'b1,
                                    enable: 1'b1, repeat_en: 1'b1, days: 7'h7F};

  typedef struct packed {
    logic             hit;
    logic [DistW-1:0] span;
    logic [2:0]       day;
  } dist_res_t;

  // Weekday sum (at most 13) folded back into 0..6.
  function automatic logic [2:0] mod7(input logic [3:0] v);
    logic [3:0] r;
    r = (v >= 4'd7) ? (v - 4'd7) : v;
    return r[2:0];
  endfunction

  function automatic logic [4:0] mod24(input logic [4:0] v);
    return (v >= 5'd24) ? (v - 5'd24) : v;
  endfunction

  function automatic logic [5:0] mod60(input logic [5:0] v);
    return (v >= 6'd60) ? (v - 6'd60) : v;
  endfunction

endpackage

`default_nettype wire

// ----- src/wnaf_slot_table.sv -----
// ============================================================================
// Alarm slot table
// Register file of alarm slots with one write port and one read port.
// ============================================================================
`default_nettype none

module wnaf_slot_table
  import wnaf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [SlotIdxW-1:0] waddr_i,
  input  wire slot_t               wdata_i,
  input  wire logic [SlotIdxW-1:0] raddr_i,
  output slot_t                    rdata_o
);

  slot_t slots_q [SlotCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        slots_q[i] <= SlotDefault;
      end
    end else if (we_i) begin
      slots_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = slots_q[raddr_i];

endmodule

`default_nettype wire

// ----- src/wnaf_dist_unit.sv -----
// ============================================================================
// Slot distance unit
// Finds the first positive distance in minutes to one slot's next alarm.
// ============================================================================
`default_nettype none

module wnaf_dist_unit
  import wnaf_pkg::*;
(
  input  wire slot_t              slot_i,
  input  wire logic [2:0]         wd_i,
  input  wire logic [NowMinW-1:0] now_min_i,
  output dist_res_t               res_o
);

  logic [NowMinW-1:0]      alarm_min;
  logic signed [NowMinW:0] base;
  logic [1:0]              dc_min;
  logic [7:0]              ok;
  logic [2:0]              first_k;
  logic                    any_ok;
  logic [DistW-1:0]        day_off;
  logic signed [DistW:0]   dist_s;

  assign alarm_min = NowMinW'(32'(slot_i.hour) * MinPerHour + 32'(slot_i.minute));
  assign base      = $signed({1'b0, alarm_min}) - $signed({1'b0, now_min_i});

  // Smallest day offset that can give a positive distance.
  always_comb begin
    priority if (base > 0) begin
      dc_min = 2'd0;
    end else if (base > -$signed((NowMinW+1)'(MinPerDay))) begin
      dc_min = 2'd1;
    end else begin
      dc_min = 2'd2;
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      ok[k] = (!slot_i.repeat_en || slot_i.days[mod7(4'(wd_i) + 4'(k))])
              && (k >= int'(dc_min));
    end
  end

  always_comb begin
    first_k = 3'd0;
    any_ok  = 1'b0;
    for (int k = 7; k >= 0; k--) begin
      if (ok[k]) begin
        first_k = 3'(k);
        any_ok  = 1'b1;
      end
    end
  end

  assign day_off = DistW'(32'(first_k) * MinPerDay);
  assign dist_s  = $signed({1'b0, day_off}) + (DistW+1)'(base);

  assign res_o.hit  = any_ok && !slot_i.hidden && slot_i.enable;
  assign res_o.span = dist_s[DistW-1:0];
  assign res_o.day  = mod7(4'(wd_i) + 4'(first_k));

endmodule

`default_nettype wire

// ----- src/weekly_next_alarm_finder.sv -----
// ============================================================================
// Weekly next-alarm finder
// Alarm slot table with a sequenced search for the nearest upcoming alarm.
// ============================================================================
//
//   Channel   Direction  Handshake                 Payload
//   --------  ---------  ------------------------  ------------------------------
//   input     in         in_valid_i / in_ready_o   cmd, slot, alarm time/flags, now
//   result    out        out_valid_o / out_ready_i found, next day/time/slot, ramp
//   config    in         APB write, pready high    sunrise_duration at address 0
//
// A write command completes in the cycle of its transfer and gives no result.
// A find steps the scan state through every slot and then registers its result in
// the finish state; a trigger first passes the disable state. The single
// distance unit serves one slot per cycle.
// Reset restores every slot to 07:00, hidden, enabled, repeating, all days.
// A waiting result does not block the next transfer; only the final cycle of a
// search stalls until the output register is free.
//
`default_nettype none

module weekly_next_alarm_finder
  import wnaf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [4:0]  alarm_hour_i,
  input  wire logic [5:0]  alarm_minute_i,
  input  wire logic        alarm_hidden_i,
  input  wire logic        alarm_enable_i,
  input  wire logic        alarm_repeat_i,
  input  wire logic [6:0]  day_mask_i,
  input  wire logic [2:0]  now_weekday_i,
  input  wire logic [4:0]  now_hour_i,
  input  wire logic [5:0]  now_minute_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [2:0]       next_day_o,
  output logic [4:0]       next_hour_o,
  output logic [5:0]       next_minute_o,
  output logic [2:0]       next_slot_o,
  output logic [13:0]      minutes_to_go_o,
  output logic [1:0]       ramp_hours_o,
  output logic [5:0]       ramp_minutes_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISABLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Sequencer and search registers.
  state_e                state_q, state_d;
  logic [SlotIdxW-1:0]   idx_q, idx_d;
  logic [2:0]            wd_q, wd_d;
  logic [NowMinW-1:0]    now_min_q, now_min_d;
  logic [DistW-1:0]      best_q, best_d;
  logic [2:0]            best_day_q, best_day_d;
  logic [SlotIdxW-1:0]   best_slot_q, best_slot_d;
  logic [4:0]            best_hour_q, best_hour_d;
  logic [5:0]            best_min_q, best_min_d;

  // Latched alarm, kept across searches that find nothing.
  logic [SlotIdxW-1:0]   chosen_q, chosen_d;
  logic [2:0]            lat_day_q, lat_day_d;
  logic [4:0]            lat_hour_q, lat_hour_d;
  logic [5:0]            lat_min_q, lat_min_d;
  logic [1:0]            lat_rh_q, lat_rh_d;
  logic [5:0]            lat_rm_q, lat_rm_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic                  found_q, found_d;
  logic [DistW-1:0]      mtg_q, mtg_d;

  logic [7:0]            sunrise_q, sunrise_d;

  // Table ports.
  logic                  tbl_we;
  logic [SlotIdxW-1:0]   tbl_waddr;
  slot_t                 tbl_wdata;
  logic [SlotIdxW-1:0]   tbl_raddr;
  slot_t                 tbl_rdata;
  dist_res_t             dres;

  logic                  in_xfer;
  logic                  hit_any;
  logic [1:0]            ramp_h;
  logic [5:0]            ramp_m;

  wnaf_slot_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  wnaf_dist_unit u_dist (
    .slot_i    (tbl_rdata),
    .wd_i      (wd_q),
    .now_min_i (now_min_q),
    .res_o     (dres)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign tbl_raddr  = (state_q == ST_DISABLE) ? chosen_q : idx_q;
  assign hit_any    = (best_q < DistW'(NoHitDist));

  // Sunrise duration split; the register never exceeds three hours.
  always_comb begin
    priority if (sunrise_q >= 8'd180) begin
      ramp_h = 2'd3;
      ramp_m = 6'(sunrise_q - 8'd180);
    end else if (sunrise_q >= 8'd120) begin
      ramp_h = 2'd2;
      ramp_m = 6'(sunrise_q - 8'd120);
    end else if (sunrise_q >= 8'd60) begin
      ramp_h = 2'd1;
      ramp_m = 6'(sunrise_q - 8'd60);
    end else begin
      ramp_h = 2'd0;
      ramp_m = 6'(sunrise_q);
    end
  end

  // Configuration register, saturated at the longest ramp.
  always_comb begin
    sunrise_d = sunrise_q;
    if (psel && penable && pwrite && pready && !paddr[2]) begin
      sunrise_d = (pwdata[7:0] > 8'(RampMax)) ? 8'(RampMax) : pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'(sunrise_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    wd_d        = wd_q;
    now_min_d   = now_min_q;
    best_d      = best_q;
    best_day_d  = best_day_q;
    best_slot_d = best_slot_q;
    best_hour_d = best_hour_q;
    best_min_d  = best_min_q;
    chosen_d    = chosen_q;
    lat_day_d   = lat_day_q;
    lat_hour_d  = lat_hour_q;
    lat_min_d   = lat_min_q;
    lat_rh_d    = lat_rh_q;
    lat_rm_d    = lat_rm_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    mtg_d       = mtg_q;
    tbl_we      = 1'b0;
    tbl_waddr   = tbl_raddr;
    tbl_wdata   = tbl_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          // Search context is captured on every accepted command; a weekday
          // code of seven stands for Sunday.
          wd_d      = (now_weekday_i == 3'd7) ? 3'd0 : now_weekday_i;
          now_min_d = NowMinW'(32'(now_hour_i) * MinPerHour + 32'(now_minute_i));
          idx_d     = '0;
          best_d    = DistW'(NoHitDist);
          case (cmd_e'(cmd_i))
            CMD_WRITE: begin
              if (32'(slot_i) < SlotCount) begin
                tbl_we              = 1'b1;
                tbl_waddr           = SlotIdxW'(slot_i);
                tbl_wdata.hour      = mod24(alarm_hour_i);
                tbl_wdata.minute    = mod60(alarm_minute_i);
                tbl_wdata.hidden    = alarm_hidden_i;
                tbl_wdata.enable    = alarm_enable_i;
                tbl_wdata.repeat_en = alarm_repeat_i;
                tbl_wdata.days      = day_mask_i;
              end
            end
            CMD_FIND: begin
              state_d = ST_SCAN;
            end
            CMD_TRIGGER: begin
              state_d = ST_DISABLE;
            end
            default: begin
              // The unused command code is dropped without a result.
            end
          endcase
        end
      end

      ST_DISABLE: begin
        // A one-shot alarm that just went off is switched off before the search.
        if (!tbl_rdata.repeat_en) begin
          tbl_we           = 1'b1;
          tbl_waddr        = chosen_q;
          tbl_wdata.enable = 1'b0;
        end
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        // Strict compare keeps the lower slot on a tie.
        if (dres.hit && (dres.span < best_q)) begin
          best_d      = dres.span;
          best_day_d  = dres.day;
          best_slot_d = idx_q;
          best_hour_d = tbl_rdata.hour;
          best_min_d  = tbl_rdata.minute;
        end
        if (idx_q == SlotIdxW'(SlotCount - 1)) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = hit_any;
          mtg_d       = hit_any ? best_q : '0;
          if (hit_any) begin
            chosen_d   = best_slot_q;
            lat_day_d  = best_day_q + 3'd1;
            lat_hour_d = best_hour_q;
            lat_min_d  = best_min_q;
            lat_rh_d   = ramp_h;
            lat_rm_d   = ramp_m;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      wd_q        <= '0;
      now_min_q   <= '0;
      best_q      <= '0;
      best_day_q  <= '0;
      best_slot_q <= '0;
      best_hour_q <= '0;
      best_min_q  <= '0;
      chosen_q    <= '0;
      lat_day_q   <= '0;
      lat_hour_q  <= '0;
      lat_min_q   <= '0;
      lat_rh_q    <= '0;
      lat_rm_q    <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      mtg_q       <= '0;
      sunrise_q   <= 8'(RampReset);
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      wd_q        <= wd_d;
      now_min_q   <= now_min_d;
      best_q      <= best_d;
      best_day_q  <= best_day_d;
      best_slot_q <= best_slot_d;
      best_hour_q <= best_hour_d;
      best_min_q  <= best_min_d;
      chosen_q    <= chosen_d;
      lat_day_q   <= lat_day_d;
      lat_hour_q  <= lat_hour_d;
      lat_min_q   <= lat_min_d;
      lat_rh_q    <= lat_rh_d;
      lat_rm_q    <= lat_rm_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      mtg_q       <= mtg_d;
      sunrise_q   <= sunrise_d;
    end
  end

  // The latched fields are only updated together with the output register,
  // so they present the result of the transfer being offered.
  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign next_day_o      = lat_day_q;
  assign next_hour_o     = lat_hour_q;
  assign next_minute_o   = lat_min_q;
  assign next_slot_o     = 3'(chosen_q);
  assign minutes_to_go_o = mtg_q;
  assign ramp_hours_o    = lat_rh_q;
  assign ramp_minutes_o  = lat_rm_q;

endmodule

`default_nettype wire

// ----- src/wnaf_checker.sv -----
// ============================================================================
// Weekly next-alarm finder checker
// Port-level assertions on result values, the result handshake and pready.
// ============================================================================
`default_nettype none

module wnaf_checker
  import wnaf_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        found_o,
  input wire logic [2:0]  next_day_o,
  input wire logic [13:0] minutes_to_go_o,
  input wire logic [5:0]  ramp_minutes_o
);

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (minutes_to_go_o == 14'd0))
    else $error("result without a hit carries a nonzero distance");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> ((minutes_to_go_o != 14'd0)
      && (minutes_to_go_o <= 14'(NumDays * MinPerDay))
      && (next_day_o != 3'd0)))
    else $error("hit result has a distance or weekday out of range");

  a_ramp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ramp_minutes_o < 6'd60))
    else $error("ramp minutes out of range");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(found_o) && $stable(minutes_to_go_o)
       && $stable(next_day_o)))
    else $error("stalled result changed before its transfer");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port inserted a wait state");

endmodule

bind weekly_next_alarm_finder wnaf_checker u_wnaf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .found_o         (found_o),
  .next_day_o      (next_day_o),
  .minutes_to_go_o (minutes_to_go_o),
  .ramp_minutes_o  (ramp_minutes_o)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// ============================================================================
// Weekly next-alarm finder testbench
// Self-checking bench: writes, finds and triggers go through a valid/ready
// driver, a transaction-level predictor forecasts each result, and a monitor compares
// every result transfer field by field under several idle and stall profiles.
// ============================================================================
module tb_top
  import wnaf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Command code that the block must swallow without a result.
  localparam logic [1:0] CmdIgnored = 2'd3;
  // Byte address of the sunrise duration register.
  localparam logic [2:0] RegSunrise = 3'd0;

  localparam int          ItemsPerPhase = 162;
  localparam int          DrainCycles   = 24;
  localparam int          HoldCycles    = 300;
  localparam int unsigned CycleLimit    = 400000;

  // One input item as it travels over the input channel.
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] slot;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       alarm_hidden;
    logic       alarm_enable;
    logic       alarm_repeat;
    logic [6:0] day_mask;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } alarm_cmd_t;

  // One result item as it leaves over the result channel.
  typedef struct packed {
    logic        found;
    logic [2:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  slot;
    logic [13:0] minutes_to_go;
    logic [1:0]  ramp_hours;
    logic [5:0]  ramp_minutes;
  } next_alarm_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals that the bench drives.
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic       in_valid_r = 1'b0;
  logic       in_ready_o;
  alarm_cmd_t drive_item = '0;

  logic        out_valid_o;
  logic        out_ready_r = 1'b0;
  logic        found_o;
  logic [2:0]  next_day_o;
  logic [4:0]  next_hour_o;
  logic [5:0]  next_minute_o;
  logic [2:0]  next_slot_o;
  logic [13:0] minutes_to_go_o;
  logic [1:0]  ramp_hours_o;
  logic [5:0]  ramp_minutes_o;

  weekly_next_alarm_finder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_r),
    .in_ready_o     (in_ready_o),
    .cmd_i          (drive_item.cmd),
    .slot_i         (drive_item.slot),
    .alarm_hour_i   (drive_item.alarm_hour),
    .alarm_minute_i (drive_item.alarm_minute),
    .alarm_hidden_i (drive_item.alarm_hidden),
    .alarm_enable_i (drive_item.alarm_enable),
    .alarm_repeat_i (drive_item.alarm_repeat),
    .day_mask_i     (drive_item.day_mask),
    .now_weekday_i  (drive_item.now_weekday),
    .now_hour_i     (drive_item.now_hour),
    .now_minute_i   (drive_item.now_minute),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_r),
    .found_o        (found_o),
    .next_day_o     (next_day_o),
    .next_hour_o    (next_hour_o),
    .next_minute_o  (next_minute_o),
    .next_slot_o    (next_slot_o),
    .minutes_to_go_o(minutes_to_go_o),
    .ramp_hours_o   (ramp_hours_o),
    .ramp_minutes_o (ramp_minutes_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shared bench state. The stimulus process owns the profile knobs and only
  // changes them at falling edges, so the clocked processes never race them.
  // --------------------------------------------------------------------------
  alarm_cmd_t  command_backlog[$];
  next_alarm_t alarm_forecast[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_armed = 1'b0;
  logic        hold_spent = 1'b0;
  int          hold_left = 0;
  int unsigned cycles_run = 0;

  // Mirror of the block: the slot table, the latched winner and the ramp.
  slot_t      slot_table[SlotCount];
  logic [2:0] picked_slot;
  logic [2:0] held_day;
  logic [4:0] held_hour;
  logic [5:0] held_minute;
  logic [1:0] held_ramp_h;
  logic [5:0] held_ramp_m;
  logic [7:0] ramp_setting;

  // Put the mirror into its post-reset state: every slot 07:00, hidden.
  function automatic void reset_mirror();
    for (int i = 0; i < SlotCount; i++) slot_table[i] = SlotDefault;
    picked_slot  = '0;
    held_day     = '0;
    held_hour    = '0;
    held_minute  = '0;
    held_ramp_h  = '0;
    held_ramp_m  = '0;
    ramp_setting = 8'(RampReset);
  endfunction

  // Apply one accepted item to the mirror. Finds and triggers push the result
  // that the block must return; writes and the unused code push nothing.
  function automatic void next_alarm_for(input alarm_cmd_t c);
    int          wd, now_min, alarm_min, gap, day;
    int          best, best_day, best_slot;
    next_alarm_t r;
    if (c.cmd == CMD_WRITE) begin
      slot_table[c.slot].hour      = 5'(int'(c.alarm_hour) % HoursPerDay);
      slot_table[c.slot].minute    = 6'(int'(c.alarm_minute) % MinPerHour);
      slot_table[c.slot].hidden    = c.alarm_hidden;
      slot_table[c.slot].enable    = c.alarm_enable;
      slot_table[c.slot].repeat_en = c.alarm_repeat;
      slot_table[c.slot].days      = c.day_mask;
    end else if (c.cmd == CMD_FIND || c.cmd == CMD_TRIGGER) begin
      // A trigger retires the current one-shot alarm before searching again.
      if (c.cmd == CMD_TRIGGER && !slot_table[picked_slot].repeat_en)
        slot_table[picked_slot].enable = 1'b0;
      wd        = int'(c.now_weekday) % NumDays;
      now_min   = int'(c.now_hour) * MinPerHour + int'(c.now_minute);
      best      = NoHitDist;
      best_day  = 0;
      best_slot = 0;
      for (int i = 0; i < SlotCount; i++) begin
        if (!slot_table[i].hidden && slot_table[i].enable) begin
          alarm_min = int'(slot_table[i].hour) * MinPerHour + int'(slot_table[i].minute);
          gap = -1;
          day = 0;
          // Walk forward day by day; a day that is not allowed keeps the
          // previous distance, so the first positive one on an allowed day wins.
          for (int dc = 0; dc <= NumDays; dc++) begin
            if (gap <= 0) begin
              day = (wd + dc) % NumDays;
              if (slot_table[i].days[day] || !slot_table[i].repeat_en)
                gap = dc * MinPerDay + alarm_min - now_min;
            end
          end
          if (gap > 0 && gap < best) begin
            best      = gap;
            best_day  = day;
            best_slot = i;
          end
        end
      end
      r.found = (best > 0 && best <= NumDays * MinPerDay);
      if (r.found) begin
        held_day    = 3'(best_day + 1);
        held_hour   = slot_table[best_slot].hour;
        held_minute = slot_table[best_slot].minute;
        picked_slot = 3'(best_slot);
        held_ramp_h = 2'((int'(ramp_setting) / MinPerHour) % HoursPerDay);
        held_ramp_m = 6'(int'(ramp_setting) % MinPerHour);
      end
      r.day           = held_day;
      r.hour          = held_hour;
      r.minute        = held_minute;
      r.slot          = picked_slot;
      r.minutes_to_go = r.found ? 14'(best) : '0;
      r.ramp_hours    = held_ramp_h;
      r.ramp_minutes  = held_ramp_m;
      alarm_forecast.push_back(r);
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the next backlog item whenever the channel is free, with
  // random idle cycles. Valid stays up with a stable payload until transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || in_ready_o) begin
      if (command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_r <= 1'b1;
        drive_item <= command_backlog.pop_front();
      end else begin
        in_valid_r <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the block fill
  // up and back-pressure its input while the driver keeps offering items.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_r <= 1'b0;
    end else if (hold_armed && !hold_spent) begin
      hold_spent  <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_r <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_r <= 1'b0;
    end else begin
      out_ready_r <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest forecast, then feed
  // the mirror with the input transfer of the same edge. A result can never
  // belong to an input accepted at the same edge, so the order is safe.
  always @(posedge clk_i) begin : monitor
    next_alarm_t seen, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_r) begin
        seen = '{found: found_o, day: next_day_o, hour: next_hour_o,
                 minute: next_minute_o, slot: next_slot_o,
                 minutes_to_go: minutes_to_go_o, ramp_hours: ramp_hours_o,
                 ramp_minutes: ramp_minutes_o};
        if (alarm_forecast.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, actual %h", $time, seen);
        end else begin
          want = alarm_forecast.pop_front();
          check_field("found", want.found, seen.found);
          check_field("next_day", want.day, seen.day);
          check_field("next_hour", want.hour, seen.hour);
          check_field("next_minute", want.minute, seen.minute);
          check_field("next_slot", want.slot, seen.slot);
          check_field("minutes_to_go", want.minutes_to_go, seen.minutes_to_go);
          check_field("ramp_hours", want.ramp_hours, seen.ramp_hours);
          check_field("ramp_minutes", want.ramp_minutes, seen.ramp_minutes);
        end
      end
      if (in_valid_r && in_ready_o) next_alarm_for(drive_item);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CycleLimit) begin
      $display("weekly_next_alarm_finder verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Item builders.
  // --------------------------------------------------------------------------
  function automatic alarm_cmd_t slot_write(input int s, input int h, input int m,
                                            input bit hid, input bit en, input bit rep,
                                            input int mask);
    alarm_cmd_t c;
    c.cmd          = CMD_WRITE;
    c.slot         = 3'(s);
    c.alarm_hour   = 5'(h);
    c.alarm_minute = 6'(m);
    c.alarm_hidden = hid;
    c.alarm_enable = en;
    c.alarm_repeat = rep;
    c.day_mask     = 7'(mask);
    c.now_weekday  = 3'($urandom_range(7));
    c.now_hour     = 5'($urandom_range(31));
    c.now_minute   = 6'($urandom_range(63));
    return c;
  endfunction

  // A find or trigger at the given current time; the write fields are noise.
  function automatic alarm_cmd_t alarm_query(input logic [1:0] op, input int wd,
                                             input int h, input int m);
    alarm_cmd_t c;
    c             = slot_write($urandom_range(7), $urandom_range(31), $urandom_range(63),
                               $urandom_range(1), $urandom_range(1), $urandom_range(1),
                               $urandom_range(127));
    c.cmd         = op;
    c.now_weekday = 3'(wd);
    c.now_hour    = 5'(h);
    c.now_minute  = 6'(m);
    return c;
  endfunction

  // Random traffic: writes of mostly visible alarms interleaved with searches,
  // a few out-of-range times and weekdays, and the odd unused command code.
  function automatic alarm_cmd_t random_command();
    alarm_cmd_t c;
    int         pick;
    pick = $urandom_range(99);
    c = alarm_query(CMD_FIND,
                    ($urandom_range(9) == 0) ? 7 : $urandom_range(6),
                    ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23),
                    ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59));
    if (pick < 42) c.cmd = CMD_WRITE;
    else if (pick < 74) c.cmd = CMD_FIND;
    else if (pick < 95) c.cmd = CMD_TRIGGER;
    else c.cmd = CmdIgnored;
    if (c.cmd == CMD_WRITE) begin
      c.alarm_hour   = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                : 5'($urandom_range(23));
      c.alarm_minute = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                : 6'($urandom_range(59));
      c.alarm_hidden = ($urandom_range(3) == 0);
      c.alarm_enable = ($urandom_range(4) != 0);
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration access: write, then read back and check the stored value,
  // which saturates at the largest ramp length.
  // --------------------------------------------------------------------------
  task automatic set_sunrise(input logic [7:0] minutes);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegSunrise;
    pwdata  <= {24'd0, minutes};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    ramp_setting = (int'(minutes) > RampMax) ? 8'(RampMax) : minutes;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("sunrise_duration readback", ramp_setting, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every item is taken and every result is back, then give the
  // block time to settle before anything else changes.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (command_backlog.size() != 0 || in_valid_r || alarm_forecast.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: a directed opening, then four random phases, each under its own
  // idle and stall profile and ramp length.
  // --------------------------------------------------------------------------
  initial begin
    int         idle_profile[4];
    int         stall_profile[4];
    logic [7:0] ramp_profile[4];
    idle_profile  = '{0, 48, 0, 19};
    stall_profile = '{0, 0, 48, 19};
    ramp_profile  = '{8'd255, 8'd0, 8'd180, 8'($urandom_range(255))};
    reset_mirror();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Every slot starts hidden, so the first search finds nothing.
    command_backlog.push_back(alarm_query(CMD_FIND, 0, 0, 0));
    // A trigger before any hit acts on slot zero, which repeats after reset.
    command_backlog.push_back(alarm_query(CMD_TRIGGER, 2, 6, 30));
    // A visible one-shot in slot zero, then a trigger that retires it at once.
    command_backlog.push_back(slot_write(0, 7, 0, 0, 1, 0, 0));
    command_backlog.push_back(alarm_query(CMD_TRIGGER, 1, 5, 0));
    // An out-of-range time folds to 07:03; weekday seven reads as Sunday.
    command_backlog.push_back(slot_write(0, 31, 63, 0, 1, 1, 127));
    command_backlog.push_back(alarm_query(CMD_FIND, 7, 0, 0));
    // Same time in slot seven: the tie goes to the lower slot.
    command_backlog.push_back(slot_write(7, 7, 3, 0, 1, 1, 127));
    command_backlog.push_back(alarm_query(CMD_FIND, 4, 12, 0));
    // A one-shot a minute away wins, then its trigger disables it.
    command_backlog.push_back(slot_write(3, 23, 59, 0, 1, 0, 0));
    command_backlog.push_back(alarm_query(CMD_FIND, 6, 23, 58));
    command_backlog.push_back(alarm_query(CMD_TRIGGER, 6, 23, 58));
    // A repeating slot with no day allowed, and a hidden slot, never win.
    command_backlog.push_back(slot_write(1, 0, 0, 0, 1, 1, 0));
    command_backlog.push_back(slot_write(2, 0, 0, 1, 1, 1, 127));
    // The current time given beyond its range is used as it stands.
    command_backlog.push_back(alarm_query(CMD_FIND, 3, 31, 63));
    // The unused code must leave the table alone.
    command_backlog.push_back(slot_write(0, 0, 0, 1, 0, 0, 0));
    command_backlog[$].cmd = CmdIgnored;
    // Leave only a Wednesday alarm at exactly now: the answer is a full week.
    command_backlog.push_back(slot_write(0, 0, 0, 1, 0, 0, 0));
    command_backlog.push_back(slot_write(7, 7, 3, 0, 0, 1, 127));
    command_backlog.push_back(slot_write(4, 12, 0, 0, 1, 1, 8));
    command_backlog.push_back(alarm_query(CMD_FIND, 3, 12, 0));
    command_backlog.push_back(alarm_query(CMD_TRIGGER, 0, 0, 0));
    wait_quiet();

    for (int p = 0; p < 4; p++) begin
      set_sunrise(ramp_profile[p]);
      @(negedge clk_i);
      send_idle_pct = idle_profile[p];
      stall_pct     = stall_profile[p];
      for (int n = 0; n < ItemsPerPhase; n++) command_backlog.push_back(random_command());
      // The long hold-off lands in the first phase, where the sender never idles.
      if (p == 0) hold_armed = 1'b1;
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("weekly_next_alarm_finder verification clean");
    end else begin
      $display("weekly_next_alarm_finder verification failed");
    end
    $finish;
  end

endmodule
